// ===== hw/rtl/deq_pkg.sv =====
// Shared definitions for the double-ended queue: request operation codes,
// response status codes and default sizes.
// No dependencies; used by double_ended_queue and deq_ram.
package deq_pkg;

  // Default sizes handed to the module parameters.
  localparam int unsigned DefaultDepth     = 16;
  localparam int unsigned DefaultDataWidth = 32;

  // Fixed widths of the request and response fields.
  localparam int unsigned ModeW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;

  // Operation requested by one input request.
  typedef enum logic [ModeW-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_REAR  = 3'd1,
    MODE_DEL_FRONT = 3'd2,
    MODE_DEL_REAR  = 3'd3,
    MODE_DISPLAY   = 3'd4
  } mode_e;

  // Status returned with every response.
  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage

// ===== hw/rtl/double_ended_queue.sv =====
// Bounded double-ended queue held in a ring buffer of DEPTH entries, with a
// head pointer and an element count. Each request inserts at the front or
// rear, deletes from the front or rear, or displays the whole queue from
// front to rear. An insert, or any answer with an empty or full status, is
// ready on the output in the cycle after it is taken; a delete reads its
// element from the store, whose read data is registered, and returns it once
// the output register is free; a display streams the stored elements one at
// a time through the single read port of the store. A new request is taken
// once the previous one has finished and the output register is free or being
// emptied. Unused operation codes are taken and answered with nothing. Stored
// elements: low DATA_WIDTH bits of the request value, returned zero-extended.
module double_ended_queue #(
  parameter int unsigned DEPTH      = deq_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = deq_pkg::DefaultDataWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [deq_pkg::ModeW-1:0]           mode_i,
  input  logic signed [deq_pkg::ValueW-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [deq_pkg::ValueW-1:0]   result_value_o,
  output logic [deq_pkg::StatusW-1:0]         status_o,
  output logic                                last_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned ValW = deq_pkg::ValueW;
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);
  localparam logic [CntW:0]   DepthSum = (CntW + 1)'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL,
    S_DISP
  } state_e;

  state_e                  state_q, state_d;
  logic [IdxW-1:0]         head_q, head_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [IdxW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic                    out_valid_q, out_valid_d;
  logic [ValW-1:0]         res_q, res_d;
  deq_pkg::status_e        status_q, status_d;
  logic                    last_q, last_d;

  logic                    out_free;
  logic                    in_acc;
  logic                    mem_we;
  logic [IdxW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0]   store_val;
  logic                    mem_re;
  logic [IdxW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0]   mem_rdata;
  logic [ValW-1:0]         rd_val;
  logic [CntW-1:0]         cnt_m1;
  logic                    disp_last;

  // Ring pointer steps with wrap at the top of the store.
  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] p);
    return (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] p);
    return (p == '0) ? LastIdx : p - 1'b1;
  endfunction

  // Entry that lies a given number of places behind the head.
  function automatic logic [IdxW-1:0] slot(input logic [IdxW-1:0] head,
                                           input logic [CntW-1:0] offset);
    logic [CntW:0] sum;
    sum = (CntW + 1)'(head) + (CntW + 1)'(offset);
    if (sum >= DepthSum) begin
      sum = sum - DepthSum;
    end
    return sum[IdxW-1:0];
  endfunction

  // Conversion between the request value and the stored width.
  if (DATA_WIDTH <= ValW) begin : g_narrow
    assign store_val = value_i[DATA_WIDTH-1:0];
    assign rd_val    = ValW'(mem_rdata);
  end else begin : g_wide
    assign store_val = DATA_WIDTH'(unsigned'(value_i));
    assign rd_val    = mem_rdata[ValW-1:0];
  end

  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (store_val),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Handshake qualifiers.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign cnt_m1     = count_q - 1'b1;
  assign disp_last  = (CntW'(idx_q) == cnt_m1);

  // Request decoding, memory accesses and response formation.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_d       = res_q;
    status_d    = status_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_waddr   = head_q;
    mem_re      = 1'b0;
    mem_raddr   = head_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (deq_pkg::mode_e'(mode_i))
            deq_pkg::MODE_INS_FRONT, deq_pkg::MODE_INS_REAR: begin
              out_valid_d = 1'b1;
              res_d       = '0;
              last_d      = 1'b1;
              if (count_q == DepthCnt) begin
                status_d = deq_pkg::STATUS_FULL;
              end else begin
                status_d = deq_pkg::STATUS_OK;
                mem_we   = 1'b1;
                count_d  = count_q + 1'b1;
                if (deq_pkg::mode_e'(mode_i) == deq_pkg::MODE_INS_FRONT) begin
                  head_d    = idx_dec(head_q);
                  mem_waddr = idx_dec(head_q);
                end else begin
                  mem_waddr = slot(head_q, count_q);
                end
              end
            end
            deq_pkg::MODE_DEL_FRONT, deq_pkg::MODE_DEL_REAR: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                res_d       = '0;
                status_d    = deq_pkg::STATUS_EMPTY;
                last_d      = 1'b1;
              end else begin
                mem_re  = 1'b1;
                count_d = cnt_m1;
                state_d = S_DEL;
                if (deq_pkg::mode_e'(mode_i) == deq_pkg::MODE_DEL_FRONT) begin
                  mem_raddr = head_q;
                  head_d    = idx_inc(head_q);
                end else begin
                  mem_raddr = slot(head_q, cnt_m1);
                end
              end
            end
            deq_pkg::MODE_DISPLAY: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                res_d       = '0;
                status_d    = deq_pkg::STATUS_EMPTY;
                last_d      = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_q;
                rd_ptr_d  = idx_inc(head_q);
                idx_d     = '0;
                state_d   = S_DISP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DEL: begin
        // The removed element arrives from the store in the cycle after the read.
        if (out_free) begin
          out_valid_d = 1'b1;
          res_d       = rd_val;
          status_d    = deq_pkg::STATUS_OK;
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_DISP: begin
        // Hand out one element and fetch the next in the same cycle.
        if (out_free) begin
          out_valid_d = 1'b1;
          res_d       = rd_val;
          status_d    = deq_pkg::STATUS_OK;
          last_d      = disp_last;
          if (disp_last) begin
            state_d = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = rd_ptr_q;
            rd_ptr_d  = idx_inc(rd_ptr_q);
            idx_d     = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and the registered response.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      status_q    <= deq_pkg::STATUS_OK;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
      status_q    <= status_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = signed'(res_q);
  assign status_o       = status_q;
  assign last_o         = last_q;

  // The element count never exceeds the size of the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("element count above depth");

  // An insert into a full queue leaves the count untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && count_q == DepthCnt &&
     (mode_i == deq_pkg::MODE_INS_FRONT || mode_i == deq_pkg::MODE_INS_REAR))
    |=> $stable(count_q))
    else $error("full insert changed the count");

  // A delete on a non-empty queue removes exactly one element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && count_q != '0 &&
     (mode_i == deq_pkg::MODE_DEL_FRONT || mode_i == deq_pkg::MODE_DEL_REAR))
    |=> (count_q == $past(cnt_m1)))
    else $error("delete did not remove one element");

  // The queue contents stay put while a display streams.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISP) |=> ($stable(count_q) && $stable(head_q)))
    else $error("queue changed during display");

endmodule

// ===== hw/rtl/deq_ram.sv =====
// Element store of the double-ended queue: one write port and one read
// port, with the read data registered.
// Depends on deq_pkg for the default sizes.
module deq_ram #(
  parameter int unsigned DEPTH      = deq_pkg::DefaultDepth,
  parameter int unsigned DATA_WIDTH = deq_pkg::DefaultDataWidth
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [DATA_WIDTH-1:0]         wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic [DATA_WIDTH-1:0]         rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== dv/double_ended_queue_test.sv =====
// Self-checking testbench for double_ended_queue: random and directed requests,
// with a local prediction of the ring buffer, checked against every response.
// Depends on deq_pkg and the double_ended_queue RTL only.
module double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = deq_pkg::DefaultDepth;
  localparam int unsigned DATA_WIDTH   = deq_pkg::DefaultDataWidth;
  localparam int unsigned ModeW        = deq_pkg::ModeW;
  localparam int unsigned ValueW       = deq_pkg::ValueW;
  localparam int unsigned StatusW      = deq_pkg::StatusW;
  localparam int unsigned IdxW         = $clog2(DEPTH);
  localparam int unsigned ModeCount    = 1 << ModeW;
  localparam int          RandomItems  = 460;
  localparam int          MaxPause     = 15;
  localparam int          MaxReported  = 10;
  localparam int          SettleCycles = 40;
  localparam int          CycleLimit   = 600_000;

  typedef struct {
    logic [ModeW-1:0]  mode;
    logic [ValueW-1:0] value;
    int                gap;
    bit                drain;
  } request_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    deq_pkg::status_e  status;
    logic              last;
  } answer_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [ModeW-1:0]         mode_i      = '0;
  logic signed [ValueW-1:0] value_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [ValueW-1:0] result_value_o;
  logic [StatusW-1:0]       status_o;
  logic                     last_o;

  // Requests waiting to be driven, and responses the queue owes us.
  request_t request_q[$];
  answer_t  answer_q[$];

  // Local image of the queue contents.
  logic [DATA_WIDTH-1:0] ring_store [DEPTH];
  logic [IdxW-1:0]       front_idx  = '0;
  logic [IdxW:0]         fill_level = '0;

  // Generator state and bookkeeping.
  int unsigned gen_fill      = 0;
  int          gen_items     = 0;
  bit          gen_calm      = 1'b0;
  bit          rx_calm       = 1'b0;
  int          hold_left     = -1;
  int          stall_left    = 0;
  int          fail_cnt      = 0;
  int          checked_cnt   = 0;
  int          full_cnt      = 0;
  int          empty_cnt     = 0;
  int          taken_cnt [ModeCount];
  longint      cycle_cnt     = 0;

  double_ended_queue #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_value_o(result_value_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
  end

  // Pause length for one request or response; calm stretches have none.
  function automatic int draw_pause(bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, MaxPause);
    return $urandom_range(0, 1);
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {1'b0, {(ValueW-1){1'b1}}};
      3: return {1'b1, {(ValueW-1){1'b0}}};
      default: return $urandom();
    endcase
  endfunction

  // Queue one request and keep the generator's idea of the fill level.
  function automatic void add_request(logic [ModeW-1:0] mode, bit drain = 1'b0);
    request_t req;
    req.mode  = mode;
    req.value = pick_value();
    req.gap   = draw_pause(gen_calm);
    req.drain = drain;
    request_q.push_back(req);
    if (mode == deq_pkg::MODE_INS_FRONT || mode == deq_pkg::MODE_INS_REAR) begin
      if (gen_fill < DEPTH) gen_fill++;
    end else if (mode == deq_pkg::MODE_DEL_FRONT || mode == deq_pkg::MODE_DEL_REAR) begin
      if (gen_fill > 0) gen_fill--;
    end
    if (mode <= deq_pkg::MODE_DISPLAY) gen_items++;
  endfunction

  function automatic void note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= MaxReported) $display("ERROR: %s", msg);
  endfunction

  function automatic void push_answer(logic [ValueW-1:0] value,
                                      deq_pkg::status_e status, logic last);
    answer_q.push_back('{value: value, status: status, last: last});
    if (status == deq_pkg::STATUS_FULL) full_cnt++;
    if (status == deq_pkg::STATUS_EMPTY) empty_cnt++;
  endfunction

  // Apply one accepted request to the local queue image and record the
  // responses that it must produce.
  function automatic void deque_apply(logic [ModeW-1:0] mode, logic [ValueW-1:0] value);
    taken_cnt[mode]++;
    case (mode)
      deq_pkg::MODE_INS_FRONT, deq_pkg::MODE_INS_REAR: begin
        if (fill_level == DEPTH) begin
          push_answer('0, deq_pkg::STATUS_FULL, 1'b1);
        end else begin
          if (mode == deq_pkg::MODE_INS_FRONT) begin
            front_idx = front_idx - 1'b1;
            ring_store[front_idx] = value[DATA_WIDTH-1:0];
          end else begin
            ring_store[IdxW'(front_idx + fill_level)] = value[DATA_WIDTH-1:0];
          end
          fill_level++;
          push_answer('0, deq_pkg::STATUS_OK, 1'b1);
        end
      end
      deq_pkg::MODE_DEL_FRONT: begin
        if (fill_level == 0) begin
          push_answer('0, deq_pkg::STATUS_EMPTY, 1'b1);
        end else begin
          push_answer(ValueW'(ring_store[front_idx]), deq_pkg::STATUS_OK, 1'b1);
          front_idx = front_idx + 1'b1;
          fill_level--;
        end
      end
      deq_pkg::MODE_DEL_REAR: begin
        if (fill_level == 0) begin
          push_answer('0, deq_pkg::STATUS_EMPTY, 1'b1);
        end else begin
          push_answer(ValueW'(ring_store[IdxW'(front_idx + fill_level - 1)]),
                      deq_pkg::STATUS_OK, 1'b1);
          fill_level--;
        end
      end
      deq_pkg::MODE_DISPLAY: begin
        if (fill_level == 0) begin
          push_answer('0, deq_pkg::STATUS_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < fill_level; i++) begin
            push_answer(ValueW'(ring_store[IdxW'(front_idx + i)]), deq_pkg::STATUS_OK,
                        i == fill_level - 1);
          end
        end
      end
      default: begin
        // Unused codes are taken silently and leave the queue alone.
      end
    endcase
  endfunction

  // Request driver: predicts on every accepted request, then offers the next
  // one after its gap, holding back a draining request until all is answered.
  always @(posedge clk_i or negedge rst_ni) begin
    bit       idle;
    bit       offer;
    request_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i     <= '0;
      value_i    <= '0;
      hold_left  = -1;
    end else begin
      idle  = !in_valid_i;
      offer = 1'b0;
      if (in_valid_i && in_ready_o) begin
        deque_apply(mode_i, value_i);
        idle = 1'b1;
      end
      if (idle) begin
        if (request_q.size() != 0) begin
          if (hold_left < 0) hold_left = request_q[0].gap;
          if (hold_left > 0) begin
            hold_left--;
          end else if (!request_q[0].drain || answer_q.size() == 0) begin
            req = request_q.pop_front();
            mode_i    <= req.mode;
            value_i   <= req.value;
            offer     = 1'b1;
            hold_left = -1;
          end
        end
        in_valid_i <= offer;
      end
    end
  end

  // Response monitor: checks each response against the oldest expectation
  // and afterwards holds the output for a random pause, none in calm stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        checked_cnt++;
        if (answer_q.size() == 0) begin
          note_failure($sformatf("unexpected response value %h status %0d last %0b",
                                 result_value_o, status_o, last_o));
        end else begin
          want = answer_q.pop_front();
          if (result_value_o !== want.value || status_o !== want.status ||
              last_o !== want.last) begin
            note_failure($sformatf({"response %0d: expected value %h status %0d last %0b,",
                                    " got value %h status %0d last %0b"},
                                   checked_cnt, want.value, want.status, want.last,
                                   result_value_o, status_o, last_o));
          end
        end
        if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
        stall_left = draw_pause(rx_calm);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready_i <= (stall_left == 0);
    end
  end

  // Watchdog against a hung queue.
  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("Timeout after %0d cycles with %0d responses outstanding",
             cycle_cnt, answer_q.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int pick;
    int ins_share;
    foreach (taken_cnt[m]) taken_cnt[m] = 0;

    // Directed opening: empty answers, extreme values, every code.
    add_request(deq_pkg::MODE_DISPLAY);
    add_request(deq_pkg::MODE_DEL_FRONT);
    add_request(deq_pkg::MODE_DEL_REAR);
    request_q.push_back('{mode: deq_pkg::MODE_INS_FRONT,
                          value: {1'b0, {(ValueW-1){1'b1}}}, gap: 0, drain: 1'b0});
    request_q.push_back('{mode: deq_pkg::MODE_INS_REAR,
                          value: {1'b1, {(ValueW-1){1'b0}}}, gap: 1, drain: 1'b0});
    request_q.push_back('{mode: deq_pkg::MODE_INS_FRONT, value: '0, gap: 0, drain: 1'b0});
    request_q.push_back('{mode: deq_pkg::MODE_INS_REAR, value: '1, gap: 2, drain: 1'b0});
    gen_fill  = 4;
    gen_items += 4;
    add_request(deq_pkg::MODE_DISPLAY, 1'b1);
    for (int m = deq_pkg::MODE_DISPLAY + 1; m < ModeCount; m++) add_request(ModeW'(m));
    add_request(deq_pkg::MODE_DEL_FRONT);
    add_request(deq_pkg::MODE_DEL_REAR);
    add_request(deq_pkg::MODE_DISPLAY);
    add_request(deq_pkg::MODE_DEL_FRONT);
    add_request(deq_pkg::MODE_DEL_REAR);
    add_request(deq_pkg::MODE_DEL_FRONT);
    add_request(deq_pkg::MODE_DISPLAY);

    // Random part, built from bursts that fill, empty or churn the queue, or send random codes.
    gen_items = 0;
    while (gen_items < RandomItems) begin
      gen_calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 5))
        0: begin
          add_request($urandom_range(0, 1) ? deq_pkg::MODE_INS_FRONT : deq_pkg::MODE_INS_REAR,
                      $urandom_range(0, 3) == 0);
          while (gen_fill < DEPTH) begin
            add_request($urandom_range(0, 1) ? deq_pkg::MODE_INS_FRONT
                                             : deq_pkg::MODE_INS_REAR);
          end
          repeat ($urandom_range(1, 3)) begin
            add_request($urandom_range(0, 1) ? deq_pkg::MODE_INS_FRONT
                                             : deq_pkg::MODE_INS_REAR);
          end
          add_request(deq_pkg::MODE_DISPLAY);
        end
        1: begin
          while (gen_fill > 0) begin
            add_request($urandom_range(0, 1) ? deq_pkg::MODE_DEL_FRONT
                                             : deq_pkg::MODE_DEL_REAR);
          end
          repeat ($urandom_range(1, 2)) begin
            add_request($urandom_range(0, 1) ? deq_pkg::MODE_DEL_FRONT
                                             : deq_pkg::MODE_DEL_REAR);
          end
          add_request(deq_pkg::MODE_DISPLAY);
        end
        5: begin
          repeat ($urandom_range(1, 3)) add_request(ModeW'($urandom_range(0, ModeCount - 1)));
        end
        default: begin
          repeat ($urandom_range(5, 20)) begin
            ins_share = (gen_fill >= 12) ? 25 : (gen_fill <= 2) ? 65 : 45;
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
              add_request(deq_pkg::MODE_DISPLAY);
            end else if (pick < 10 + ins_share) begin
              add_request($urandom_range(0, 1) ? deq_pkg::MODE_INS_FRONT
                                               : deq_pkg::MODE_INS_REAR);
            end else begin
              add_request($urandom_range(0, 1) ? deq_pkg::MODE_DEL_FRONT
                                               : deq_pkg::MODE_DEL_REAR);
            end
          end
        end
      endcase
    end

    // Reset, then let the driver and monitor run.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Summary: %0d front inserts, %0d rear inserts, %0d front deletes,",
             taken_cnt[deq_pkg::MODE_INS_FRONT], taken_cnt[deq_pkg::MODE_INS_REAR],
             taken_cnt[deq_pkg::MODE_DEL_FRONT]);
    $display("Summary: %0d rear deletes, %0d displays, %0d responses checked, %0d full, %0d empty",
             taken_cnt[deq_pkg::MODE_DEL_REAR], taken_cnt[deq_pkg::MODE_DISPLAY],
             checked_cnt, full_cnt, empty_cnt);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures in total", fail_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
